>>> src/id3fl_pkg.sv
// Shared types and constants for the ID3v2 frame locator.
package id3fl_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_TAG_HDR = 3'd0,
        PH_EXT_HDR = 3'd1,
        PH_FRM_HDR = 3'd2,
        PH_DATA    = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    // Result kind codes
    typedef enum logic [2:0] {
        KIND_TAG_HDR = 3'd0,
        KIND_FRAME   = 3'd1,
        KIND_PADDING = 3'd2,
        KIND_TAG_END = 3'd3,
        KIND_STOPPED = 3'd4
    } kind_t;

    // Configuration register indexes
    localparam logic REG_TARGET_ID     = 1'b0;
    localparam logic REG_STOP_ON_MATCH = 1'b1;

    localparam int  HDR_LEN      = 10;
    localparam int  EXT_FLAG_BIT = 6;
    localparam int  FIFO_DEPTH   = 4;
    localparam int  PTR_W        = 2;
    localparam int  CNT_W        = 3;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] frame_id;
        logic [31:0] size_value;
        logic [31:0] frame_offset;
        logic        is_match;
        logic [7:0]  tag_flags;
    } result_t;

endpackage

>>> src/id3v2_frame_locator.sv
// Byte-serial ID3v2 tag and frame header locator with a small result queue.
//
//   channel  signals                                   direction
//   input    in_valid, in_stall, data_byte, start_req  in (stall out)
//   output   out_valid, out_stall, kind, frame_id,     out (stall in)
//            size_value, frame_offset, is_match, tag_flags
//   config   wr_en, wr_index, wr_data                  in
//
// One byte is taken per cycle; its results enter a 4-entry result queue on
// the same edge and leave one per cycle unless out_stall. A byte can yield
// two results, so the input stalls while fewer than two queue entries are
// free. Reset clears the parser state, the queue and the registers; with
// no start_req after reset the first byte is taken as tag byte 0.
module id3v2_frame_locator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        start_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [31:0] frame_id,
    output logic [31:0] size_value,
    output logic [31:0] frame_offset,
    output logic        is_match,
    output logic [7:0]  tag_flags,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [31:0] wr_data
);
    import id3fl_pkg::*;

    logic [31:0] target_id_reg;
    logic        stop_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, count_reg, size_reg, id_reg, fs_reg;
    logic [28:0] limit_reg;
    logic [7:0]  flags_reg;

    phase_t      e_phase;
    logic [31:0] e_pos, e_count, e_size, e_id, e_fs;
    logic [28:0] e_limit;
    logic [7:0]  e_flags;

    logic [31:0] count_next, size_next, id_next, fs_next, pos_next, cnt_inc;
    logic [28:0] limit_next;
    logic [7:0]  flags_next;
    logic        hdr_last, ext_end, data_end, pad_hit, match, stop_hit, at_end, enter;

    result_t     r0, r1;
    logic        r0_valid, r1_valid;

    result_t     fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic        accept, pop;
    logic [CNT_W-1:0] n_push;

    assign in_stall  = (fill_reg > CNT_W'(FIFO_DEPTH - 2));
    assign accept    = in_valid && !in_stall;
    assign out_valid = (fill_reg != '0);
    assign pop       = out_valid && !out_stall;

    // A start byte sees the parser as freshly reset
    always_comb
    begin
        if (start_req)
        begin
            e_phase = PH_TAG_HDR;
            e_pos   = '0;
            e_count = '0;
            e_size  = '0;
            e_id    = '0;
            e_fs    = '0;
            e_limit = '0;
            e_flags = '0;
        end
        else
        begin
            e_phase = phase_reg;
            e_pos   = pos_reg;
            e_count = count_reg;
            e_size  = size_reg;
            e_id    = id_reg;
            e_fs    = fs_reg;
            e_limit = limit_reg;
            e_flags = flags_reg;
        end
    end

    assign cnt_inc  = e_count + 32'd1;
    assign pos_next = e_pos + 32'd1;
    assign hdr_last = (e_count == 32'(HDR_LEN - 1));
    assign ext_end  = (cnt_inc >= 32'(HDR_LEN));
    assign data_end = (cnt_inc >= e_size);
    assign pad_hit  = (e_phase == PH_FRM_HDR) && (e_count == 32'd0) && (data_byte == 8'd0);

    // Datapath updates
    always_comb
    begin
        count_next = e_count;
        size_next  = e_size;
        id_next    = e_id;
        fs_next    = e_fs;
        limit_next = e_limit;
        flags_next = e_flags;
        case (e_phase)
            PH_TAG_HDR:
            begin
                if (e_count == 32'd5)
                    flags_next = data_byte;
                else if (e_count == 32'd6)
                    size_next = {25'd0, data_byte[6:0]};
                else if (e_count > 32'd6)
                    size_next = {4'd0, e_size[20:0], data_byte[6:0]};
                count_next = cnt_inc;
                if (hdr_last)
                begin
                    limit_next = {1'b0, size_next[27:0]} + 29'(HDR_LEN);
                    count_next = '0;
                end
            end
            PH_EXT_HDR:
            begin
                count_next = ext_end ? '0 : cnt_inc;
            end
            PH_FRM_HDR:
            begin
                if (e_count == 32'd0)
                begin
                    fs_next = e_pos;
                    id_next = {24'd0, data_byte};
                end
                else if (e_count < 32'd4)
                    id_next = {e_id[23:0], data_byte};
                else if (e_count == 32'd4)
                    size_next = {24'd0, data_byte};
                else if (e_count < 32'd8)
                    size_next = {e_size[23:0], data_byte};
                count_next = hdr_last ? '0 : cnt_inc;
            end
            PH_DATA:
            begin
                count_next = data_end ? '0 : cnt_inc;
            end
            default:
            begin
                count_next = e_count;
            end
        endcase
    end

    assign match    = (id_next == target_id_reg);
    assign stop_hit = match && stop_reg;
    assign at_end   = ({3'd0, limit_next} <= pos_next);

    // Points where a frame header could begin
    always_comb
    begin
        case (e_phase)
            PH_TAG_HDR: enter = hdr_last && !flags_next[EXT_FLAG_BIT];
            PH_EXT_HDR: enter = ext_end;
            PH_FRM_HDR: enter = hdr_last && !stop_hit && (size_next == 32'd0);
            PH_DATA:    enter = data_end;
            default:    enter = 1'b0;
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = e_phase;
        case (e_phase)
            PH_TAG_HDR:
            begin
                if (hdr_last && flags_next[EXT_FLAG_BIT])
                    phase_next = PH_EXT_HDR;
            end
            PH_FRM_HDR:
            begin
                if (pad_hit)
                    phase_next = PH_DONE;
                else if (hdr_last && stop_hit)
                    phase_next = PH_DONE;
                else if (hdr_last && (size_next != 32'd0))
                    phase_next = PH_DATA;
            end
            default:
            begin
                phase_next = e_phase;
            end
        endcase
        if (enter)
            phase_next = at_end ? PH_DONE : PH_FRM_HDR;
    end

    // Results of the current byte
    always_comb
    begin
        r0       = '{kind: KIND_TAG_HDR, frame_id: '0, size_value: '0,
                     frame_offset: '0, is_match: 1'b0, tag_flags: flags_next};
        r1       = r0;
        r0_valid = 1'b0;
        r1_valid = 1'b0;
        if ((e_phase == PH_TAG_HDR) && hdr_last)
        begin
            r0_valid      = 1'b1;
            r0.size_value = size_next;
        end
        else if (pad_hit)
        begin
            r0_valid        = 1'b1;
            r0.kind         = KIND_PADDING;
            r0.frame_offset = e_pos;
        end
        else if ((e_phase == PH_FRM_HDR) && hdr_last)
        begin
            r0_valid        = 1'b1;
            r0.kind         = KIND_FRAME;
            r0.frame_id     = id_next;
            r0.size_value   = size_next;
            r0.frame_offset = fs_next;
            r0.is_match     = match;
            if (stop_hit)
            begin
                r1_valid = 1'b1;
                r1       = r0;
                r1.kind  = KIND_STOPPED;
            end
        end
        if (enter && at_end)
        begin
            if (r0_valid)
            begin
                r1_valid        = 1'b1;
                r1.kind         = KIND_TAG_END;
                r1.frame_offset = pos_next;
            end
            else
            begin
                r0_valid        = 1'b1;
                r0.kind         = KIND_TAG_END;
                r0.frame_offset = pos_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_id_reg <= '0;
            stop_reg      <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TARGET_ID:     target_id_reg <= wr_data;
                REG_STOP_ON_MATCH: stop_reg      <= wr_data[0];
                default:           stop_reg      <= stop_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TAG_HDR;
            pos_reg   <= '0;
            count_reg <= '0;
            size_reg  <= '0;
            id_reg    <= '0;
            fs_reg    <= '0;
            limit_reg <= '0;
            flags_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            size_reg  <= size_next;
            id_reg    <= id_next;
            fs_reg    <= fs_next;
            limit_reg <= limit_next;
            flags_reg <= flags_next;
        end
    end

    // Result queue: up to two pushes and one pop per cycle
    assign n_push = accept ? (CNT_W'(r0_valid) + CNT_W'(r1_valid)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + n_push[PTR_W-1:0];
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fill_reg <= fill_reg + n_push - CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && r0_valid)
            fifo_reg[wr_ptr_reg] <= r0;
        if (accept && r1_valid)
            fifo_reg[wr_ptr_reg + PTR_W'(1)] <= r1;
    end

    assign kind         = fifo_reg[rd_ptr_reg].kind;
    assign frame_id     = fifo_reg[rd_ptr_reg].frame_id;
    assign size_value   = fifo_reg[rd_ptr_reg].size_value;
    assign frame_offset = fifo_reg[rd_ptr_reg].frame_offset;
    assign is_match     = fifo_reg[rd_ptr_reg].is_match;
    assign tag_flags    = fifo_reg[rd_ptr_reg].tag_flags;

endmodule
